### hdl/json_array_element_splitter_core_macros.svh
// Assertion helpers shared by the checker.
`ifndef JSON_ARRAY_ELEMENT_SPLITTER_CORE_MACROS_SVH
`define JSON_ARRAY_ELEMENT_SPLITTER_CORE_MACROS_SVH

`define JAES_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define JAES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/jaes_pkg.sv
package jaes_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int MAX_BUFFER   = 4096;
  localparam int DEPTH_BITS   = 8;

  localparam int ELIM_W = 7;
  localparam int BSIZE_W = 13;
  localparam int IDX_W = 6;
  localparam int POS_W = 13;

  localparam logic [ELIM_W-1:0]  ELIM_MAX  = ELIM_W'(MAX_ELEMENTS);
  localparam logic [BSIZE_W-1:0] BSIZE_MAX = BSIZE_W'(MAX_BUFFER);
  localparam logic [ELIM_W-1:0]  ELIM_RST  = 7'd16;
  localparam logic [BSIZE_W-1:0] BSIZE_RST = 13'd256;

  localparam logic [DEPTH_BITS-1:0] BRACKET_MAX = '1;
  localparam logic signed [DEPTH_BITS-1:0] BRACE_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] BRACE_MIN = -BRACE_MAX;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_APOS     = 8'h27;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_TAB      = 8'h09;

  localparam logic REG_ELEMENT_LIMIT = 1'b0;
  localparam logic REG_BUFFER_SIZE   = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r1;
    res_t       r0;
  } pair_t;

  typedef struct packed {
    logic [ELIM_W-1:0]  element_limit;
    logic [BSIZE_W-1:0] buffer_size;
  } cfg_t;

endpackage

### hdl/jaes_regs.sv
module jaes_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output jaes_pkg::cfg_t cfg_o
);
  import jaes_pkg::*;

  logic [ELIM_W-1:0]  elim_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic               wr_en;
  logic               sel_bit;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign sel_bit = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elim_q  <= ELIM_RST;
      bsize_q <= BSIZE_RST;
    end else if (wr_en) begin
      if (sel_bit == REG_ELEMENT_LIMIT) elim_q <= pwdata[ELIM_W-1:0];
      else bsize_q <= pwdata[BSIZE_W-1:0];
    end
  end

  always_comb begin
    if (sel_bit == REG_ELEMENT_LIMIT) prdata = {{(32-ELIM_W){1'b0}}, elim_q};
    else prdata = {{(32-BSIZE_W){1'b0}}, bsize_q};
    if (paddr[1:0] != 2'b00) prdata = '0;
  end

  assign cfg_o.element_limit = elim_q;
  assign cfg_o.buffer_size   = bsize_q;

endmodule

### hdl/jaes_parse.sv
module jaes_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jaes_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      ch_i,
  input  logic            end_i,
  input  logic            space_ok_i,
  output jaes_pkg::pair_t pair_o
);
  import jaes_pkg::*;

  logic                         in_valid_q;
  logic [7:0]                   ch_q;
  logic                         end_q;
  logic                         advance;

  logic                         dq_q, dq_d;
  logic                         ap_q, ap_d;
  logic [DEPTH_BITS-1:0]        brk_q, brk_d;
  logic signed [DEPTH_BITS-1:0] brc_q, brc_d;
  logic [IDX_W-1:0]             cur_q, cur_d;
  logic [POS_W-1:0]             wpos_q, wpos_d;
  logic                         await_q, await_d;
  logic                         halt_q, halt_d;

  assign advance    = in_valid_q & space_ok_i;
  assign in_ready_o = ~in_valid_q | space_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else in_valid_q <= (in_valid_i & in_ready_o) | (in_valid_q & ~advance);
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q  <= ch_i;
      end_q <= end_i;
    end
  end

  always_comb begin
    logic               in_str;
    logic               top;
    logic               put;
    logic               close_c;
    logic               err_c;
    logic [BSIZE_W-1:0] size_eff;
    logic [ELIM_W-1:0]  lim_eff;
    logic [POS_W-1:0]   put_pos;
    logic [1:0]         cnt;
    res_t               r0;
    res_t               r1;

    dq_d = dq_q; ap_d = ap_q; brk_d = brk_q; brc_d = brc_q;
    cur_d = cur_q; wpos_d = wpos_q; await_d = await_q; halt_d = halt_q;
    put = 1'b0; close_c = 1'b0; err_c = 1'b0;
    in_str = dq_q | ap_q;
    top = (brc_q == '0) && (brk_q == '0);
    size_eff = (cfg_i.buffer_size > BSIZE_MAX) ? BSIZE_MAX : cfg_i.buffer_size;
    lim_eff = (cfg_i.element_limit > ELIM_MAX) ? ELIM_MAX : cfg_i.element_limit;
    put_pos = (wpos_q >= size_eff) ? '0 : wpos_q;
    cnt = 2'd0;
    r0 = '0;
    r1 = '0;

    if (!halt_q && await_q) begin
      await_d = 1'b0;
    end else if (!halt_q) begin
      case (ch_q)
        CH_SPACE: put = in_str;
        CH_NL, CH_TAB: put = 1'b0;
        CH_APOS: begin
          if (!dq_q) ap_d = ~ap_q;
          put = ~top;
        end
        CH_DQUOTE: begin
          if (!ap_q) dq_d = ~dq_q;
          put = ~top;
        end
        CH_LBRACKET: begin
          put = 1'b1;
          if (!in_str && brk_q != BRACKET_MAX) brk_d = brk_q + 1'b1;
        end
        CH_RBRACKET: begin
          if (!in_str && brk_q != '0) begin
            put = 1'b1;
            brk_d = brk_q - 1'b1;
          end
        end
        CH_LBRACE: begin
          put = 1'b1;
          if (!in_str && brk_q == '0 && brc_q < BRACE_MAX) brc_d = brc_q + 1'b1;
        end
        CH_RBRACE: begin
          put = 1'b1;
          if (!in_str && brk_q == '0 && brc_q > BRACE_MIN) brc_d = brc_q - 1'b1;
        end
        CH_COMMA: begin
          if (in_str || !top) begin
            put = 1'b1;
          end else begin
            close_c = 1'b1;
            wpos_d = '0;
            if (({1'b0, cur_q} + 7'd1) >= lim_eff) begin
              err_c = 1'b1;
              halt_d = 1'b1;
            end else begin
              cur_d = cur_q + 1'b1;
            end
          end
        end
        default: put = 1'b1;
      endcase
    end

    if (put) begin
      wpos_d = put_pos + 1'b1;
      r0.kind = KIND_DATA;
      r0.idx  = cur_q;
      r0.pos  = put_pos;
      r0.data = ch_q;
      cnt = 2'd1;
    end
    if (close_c) begin
      r0.kind = KIND_CLOSE;
      r0.idx  = cur_q;
      r0.pos  = wpos_q;
      cnt = 2'd1;
    end
    if (err_c) begin
      r1.kind = KIND_ERROR;
      r1.idx  = cur_q;
      cnt = 2'd2;
    end
    if (end_q && !halt_d) begin
      if (cnt == 2'd0) begin
        r0.kind = KIND_CLOSE;
        r0.idx  = cur_d;
        r0.pos  = wpos_d;
      end else begin
        r1.kind = KIND_CLOSE;
        r1.idx  = cur_d;
        r1.pos  = wpos_d;
      end
      cnt = cnt + 2'd1;
    end
    r0.last = (cnt == 2'd1);
    r1.last = 1'b1;

    if (end_q) begin
      dq_d = 1'b0; ap_d = 1'b0; brk_d = '0; brc_d = '0;
      cur_d = '0; wpos_d = '0; await_d = 1'b1; halt_d = 1'b0;
    end

    pair_o.cnt = advance ? cnt : 2'd0;
    pair_o.r0  = r0;
    pair_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_q <= 1'b0; ap_q <= 1'b0; brk_q <= '0; brc_q <= '0;
      cur_q <= '0; wpos_q <= '0; await_q <= 1'b1; halt_q <= 1'b0;
    end else if (advance) begin
      dq_q <= dq_d; ap_q <= ap_d; brk_q <= brk_d; brc_q <= brc_d;
      cur_q <= cur_d; wpos_q <= wpos_d; await_q <= await_d; halt_q <= halt_d;
    end
  end

endmodule

### hdl/jaes_outq.sv
module jaes_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jaes_pkg::pair_t pair_i,
  output logic            space_ok_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output jaes_pkg::res_t  out_o
);
  import jaes_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o & out_ready_i;
  assign space_ok_o  = cnt_q <= (PTR_W + 1)'(DEPTH - 2);
  assign out_o       = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (pair_i.cnt != 2'd0) mem[wr_ptr_q] <= pair_i.r0;
    if (pair_i.cnt == 2'd2) mem[wr_ptr_q + 1'b1] <= pair_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(pair_i.cnt);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_q + (PTR_W + 1)'(pair_i.cnt) - (PTR_W + 1)'(pop);
    end
  end

endmodule

### hdl/json_array_element_splitter_core.sv
// An accepted input word is registered in the parser, and its results go to the output
// queue. Throughput: one input word per cycle while the queue has space; one result
// word per cycle while m_axis_tready is high, so two results of one character go out in turn.
// Reset: rst_ni is asynchronous, active low; it clears the text state and the
// result queue and sets element_limit to 16 and buffer_size to 256.
module json_array_element_splitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // text_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] element_index, [18:6] position, [26:19] data
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jaes_pkg::*;

  cfg_t  cfg;
  pair_t pair;
  res_t  head;
  logic  space_ok;

  jaes_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jaes_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ch_i       (s_axis_tdata),
    .end_i      (s_axis_tlast),
    .space_ok_i (space_ok),
    .pair_o     (pair)
  );

  jaes_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pair),
    .space_ok_o  (space_ok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (head)
  );

  assign m_axis_tdata = {5'd0, head.data, head.pos, head.idx};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

### hdl/jaes_checker.sv
`include "json_array_element_splitter_core_macros.svh"

module jaes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import jaes_pkg::*;

  logic        out_wait;
  logic [34:0] out_word;
  logic        is_err;
  logic        is_ctl;

  assign out_wait = m_axis_tvalid && !m_axis_tready;
  assign out_word = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign is_err   = m_axis_tvalid && (m_axis_tuser == KIND_ERROR);
  assign is_ctl   = m_axis_tvalid && (m_axis_tuser != KIND_DATA);

  `JAES_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(out_word), "held word changed")
  `JAES_ASSERT_SAME(a_err_last, is_err, m_axis_tlast, "error word not last of run")
  `JAES_ASSERT_SAME(a_ctl_nodata, is_ctl, m_axis_tdata[26:19] == 8'd0, "control word carries data")
  `JAES_ASSERT_SAME(a_err_pos, is_err, m_axis_tdata[31:6] == 26'd0, "error word carries position")

endmodule

bind json_array_element_splitter_core jaes_checker u_jaes_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import jaes_pkg::*;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam int LONG_STALL = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_CHARS = 16;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       hold;
  } char_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  json_array_element_splitter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  char_item_t  chars_to_send[$];
  res_t        split_words_due[$];
  logic [7:0]  txt[$];

  int tx_style = 0;
  int rx_style = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int stall_left = 0;
  logic stall_req = 1'b0;

  int chars_sent = 0;
  int texts_sent = 0;
  int words_seen = 0;
  int miss_cnt = 0;
  int settings_cnt = 0;

  // splitter state as the block should hold it
  logic [ELIM_W-1:0]  cfg_elem_limit = ELIM_RST;
  logic [BSIZE_W-1:0] cfg_buf_size = BSIZE_RST;
  logic               in_dq = 1'b0;
  logic               in_ap = 1'b0;
  logic [7:0]         bracket_lvl = 8'd0;
  logic signed [7:0]  brace_lvl = 8'sd0;
  int unsigned        elem_cur = 0;
  int unsigned        wr_pos = 0;
  logic               skip_open = 1'b1;
  logic               halted = 1'b0;
  int                 run_words = 0;

  function automatic int draw_wait(int style);
    case (style)
      0: return 0;
      1: return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 14) : 0;
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic void post_word(kind_e k, int unsigned idx, int unsigned pos,
                                    logic [7:0] d);
    res_t r;
    r.kind = k;
    r.idx  = idx[IDX_W-1:0];
    r.pos  = pos[POS_W-1:0];
    r.data = d;
    r.last = 1'b0;
    split_words_due.push_back(r);
    run_words++;
  endfunction

  function automatic void store_byte(logic [7:0] c);
    int unsigned size;
    size = (cfg_buf_size > BSIZE_MAX) ? MAX_BUFFER : cfg_buf_size;
    if (wr_pos >= size) wr_pos = 0;
    post_word(KIND_DATA, elem_cur, wr_pos, c);
    wr_pos++;
  endfunction

  function automatic void clear_text();
    in_dq = 1'b0;
    in_ap = 1'b0;
    bracket_lvl = 8'd0;
    brace_lvl = 8'sd0;
    elem_cur = 0;
    wr_pos = 0;
    skip_open = 1'b1;
    halted = 1'b0;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    logic in_str;
    logic top;
    int unsigned lim;
    in_str = in_dq | in_ap;
    top = (brace_lvl == 0) && (bracket_lvl == 0);
    case (c)
      CH_SPACE: if (in_str) store_byte(c);
      CH_NL, CH_TAB: ;
      CH_APOS: begin
        if (!in_dq) in_ap = !in_ap;
        if (!top) store_byte(c);
      end
      CH_DQUOTE: begin
        if (!in_ap) in_dq = !in_dq;
        if (!top) store_byte(c);
      end
      CH_LBRACKET: begin
        store_byte(c);
        if (!in_str && bracket_lvl != BRACKET_MAX) bracket_lvl++;
      end
      CH_RBRACKET: if (!in_str && bracket_lvl != 0) begin
        store_byte(c);
        bracket_lvl--;
      end
      CH_LBRACE: begin
        store_byte(c);
        if (!in_str && bracket_lvl == 0 && brace_lvl < BRACE_MAX) brace_lvl++;
      end
      CH_RBRACE: begin
        store_byte(c);
        if (!in_str && bracket_lvl == 0 && brace_lvl > BRACE_MIN) brace_lvl--;
      end
      CH_COMMA: begin
        if (in_str || !top) begin
          store_byte(c);
        end else begin
          post_word(KIND_CLOSE, elem_cur, wr_pos, 8'h00);
          wr_pos = 0;
          lim = (cfg_elem_limit > ELIM_MAX) ? MAX_ELEMENTS : cfg_elem_limit;
          if (elem_cur + 1 >= lim) begin
            post_word(KIND_ERROR, elem_cur, 0, 8'h00);
            halted = 1'b1;
          end else begin
            elem_cur++;
          end
        end
      end
      default: store_byte(c);
    endcase
  endfunction

  function automatic void split_char(logic [7:0] c, logic fin);
    res_t r;
    run_words = 0;
    if (halted) begin
      if (fin) clear_text();
      return;
    end
    if (skip_open) skip_open = 1'b0;
    else parse_char(c);
    if (fin) begin
      if (!halted) post_word(KIND_CLOSE, elem_cur, wr_pos, 8'h00);
      clear_text();
    end
    if (run_words > 0) begin
      r = split_words_due.pop_back();
      r.last = 1'b1;
      split_words_due.push_back(r);
    end
  endfunction

  function automatic void log_miss(string what, res_t want, res_t got);
    miss_cnt++;
    if (miss_cnt <= 10) begin
      $display("%0t mismatch (%s): expected kind=%0d idx=%0d pos=%0d data=%02h last=%0b",
               $realtime, what, want.kind, want.idx, want.pos, want.data, want.last);
      $display("  got kind=%0d idx=%0d pos=%0d data=%02h last=%0b",
               got.kind, got.idx, got.pos, got.data, got.last);
    end
  endfunction

  // stimulus sender
  always @(posedge clk_i) begin
    char_item_t it;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        split_char(s_axis_tdata, s_axis_tlast);
        chars_sent++;
        if (s_axis_tlast) texts_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (chars_to_send.size() != 0 &&
                     (!chars_to_send[0].hold || split_words_due.size() == 0)) begin
          it = chars_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= it.ch;
          s_axis_tlast  <= it.fin;
          tx_wait = draw_wait(tx_style);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (stall_req) begin
        stall_left = LONG_STALL;
        stall_req = 1'b0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.idx  = m_axis_tdata[5:0];
        got.pos  = m_axis_tdata[18:6];
        got.data = m_axis_tdata[26:19];
        got.last = m_axis_tlast;
        words_seen++;
        if (split_words_due.size() == 0) begin
          log_miss("word with nothing expected", '0, got);
        end else begin
          want = split_words_due.pop_front();
          if (got !== want) log_miss("field mismatch", want, got);
        end
        rx_wait = draw_wait(rx_style);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_COMMA || b == CH_LBRACKET || b == CH_RBRACKET || b == CH_LBRACE ||
           b == CH_RBRACE || b == CH_DQUOTE || b == CH_APOS)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] pick_syntax();
    case ($urandom_range(0, 10))
      0: return CH_LBRACKET;
      1: return CH_RBRACKET;
      2: return CH_LBRACE;
      3: return CH_RBRACE;
      4: return CH_COMMA;
      5: return CH_DQUOTE;
      6: return CH_APOS;
      7: return CH_SPACE;
      8: return CH_NL;
      9: return CH_TAB;
      default: return plain_byte();
    endcase
  endfunction

  function automatic void gen_leaf();
    logic [7:0] q;
    if ($urandom_range(0, 1) != 0) begin
      repeat ($urandom_range(1, 3)) txt.push_back(plain_byte());
    end else begin
      q = ($urandom_range(0, 1) != 0) ? CH_DQUOTE : CH_APOS;
      txt.push_back(q);
      repeat ($urandom_range(0, 4))
        txt.push_back(($urandom_range(0, 1) != 0) ? pick_syntax() : plain_byte());
      txt.push_back(q);
    end
  endfunction

  function automatic void gen_value();
    int n;
    if ($urandom_range(0, 3) == 0)
      txt.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_NL);
    case ($urandom_range(0, 5))
      0: begin
        txt.push_back(CH_LBRACKET);
        n = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
          if (k != 0) txt.push_back(CH_COMMA);
          gen_leaf();
        end
        txt.push_back(CH_RBRACKET);
      end
      1: begin
        txt.push_back(CH_LBRACE);
        gen_leaf();
        txt.push_back(CH_COLON);
        gen_leaf();
        if ($urandom_range(0, 1) != 0) begin
          txt.push_back(CH_COMMA);
          gen_leaf();
          txt.push_back(CH_COLON);
          gen_leaf();
        end
        txt.push_back(CH_RBRACE);
      end
      default: gen_leaf();
    endcase
    if ($urandom_range(0, 3) == 0) txt.push_back(CH_TAB);
  endfunction

  function automatic void gen_text(int unsigned eff_limit);
    int unsigned n;
    int unsigned cut;
    txt.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12))
        txt.push_back(($urandom_range(0, 1) != 0) ? pick_syntax() : 8'($urandom));
      return;
    end
    txt.push_back(CH_LBRACKET);
    if ($urandom_range(0, 7) == 0) begin
      repeat (eff_limit) begin
        txt.push_back(plain_byte());
        txt.push_back(CH_COMMA);
      end
      txt.push_back(plain_byte());
    end else begin
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        if (k != 0) txt.push_back(CH_COMMA);
        gen_value();
      end
    end
    txt.push_back(CH_RBRACKET);
    case ($urandom_range(0, 9))
      0: begin
        cut = $urandom_range(1, txt.size());
        while (txt.size() > cut) void'(txt.pop_back());
      end
      1: txt.insert($urandom_range(1, txt.size() - 1), pick_syntax());
      2: txt[txt.size() - 1] = CH_COMMA;
      default: ;
    endcase
  endfunction

  function automatic void queue_text(logic hold);
    char_item_t it;
    foreach (txt[i]) begin
      it.ch   = txt[i];
      it.fin  = (i == txt.size() - 1);
      it.hold = hold && (i == 0);
      chars_to_send.push_back(it);
    end
  endfunction

  task automatic reg_write(logic sel, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_ELEMENT_LIMIT) cfg_elem_limit = val[ELIM_W-1:0];
    else cfg_buf_size = val[BSIZE_W-1:0];
  endtask

  task automatic settle();
    while (chars_to_send.size() != 0 || s_axis_tvalid || split_words_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int lim_tab[8];
    int bsz_tab[8];
    int lim;
    int bsz;
    int unsigned eff;
    int phase_chars;
    lim_tab = '{1, 0, 64, 127, 3, 5, -1, 16};
    bsz_tab = '{4, 0, 4096, 8191, 1, 7, -1, 256};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // lone opening char, then the special bytes, quotes, stray closers, depth
    txt = '{8'hFF};
    queue_text(1'b0);
    txt = '{CH_LBRACKET, 8'h00, CH_COMMA, 8'hFF, CH_SPACE, CH_DQUOTE, CH_SPACE, CH_COMMA,
            CH_RBRACKET, CH_DQUOTE, CH_LBRACKET, CH_COMMA, CH_RBRACKET, CH_RBRACKET,
            CH_LBRACE, CH_APOS, CH_COMMA, CH_RBRACE, CH_TAB, CH_NL, CH_RBRACKET};
    queue_text(1'b0);

    for (int p = 0; p < 8; p++) begin
      settle();
      lim = lim_tab[p];
      bsz = bsz_tab[p];
      if (lim < 0) begin
        lim = $urandom_range(1, 20);
        bsz = $urandom_range(1, 16);
      end
      reg_write(REG_ELEMENT_LIMIT, 32'(lim));
      reg_write(REG_BUFFER_SIZE, 32'(bsz));
      settings_cnt++;
      @(negedge clk_i);
      eff = (lim == 0) ? 1 : ((lim > MAX_ELEMENTS) ? MAX_ELEMENTS : lim);
      tx_style = p % 3;
      rx_style = (p + 1) % 3;
      if (p == 5) begin
        tx_style = 0;
        stall_req = 1'b1;
      end
      if (p == 2) begin
        txt.delete();
        repeat (259) txt.push_back(CH_LBRACKET);
        repeat (3) txt.push_back(CH_RBRACKET);
        txt.push_back(CH_COMMA);
        queue_text(1'b0);
      end
      if (p == 3) begin
        txt = '{CH_LBRACKET};
        repeat (130) txt.push_back(CH_LBRACE);
        txt.push_back(CH_COMMA);
        queue_text(1'b0);
        txt = '{CH_LBRACKET};
        repeat (130) txt.push_back(CH_RBRACE);
        txt.push_back(CH_COMMA);
        queue_text(1'b0);
      end
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        gen_text(eff);
        queue_text(phase_chars == 0 || $urandom_range(0, 5) == 0);
        phase_chars += txt.size();
      end
    end

    settle();
    $display("Sent %0d characters in %0d texts over %0d register settings;",
             chars_sent, texts_sent, settings_cnt);
    $display("checked %0d result words, %0d mismatches.", words_seen, miss_cnt);
    if (miss_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
